@@ rtl/sha256_message_digest_unit_defines.svh @@
// Assertion macros for the SHA-256 digest unit.
// Depends on nothing; taken in by the files that assert.
`ifndef SHA256_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 same-cycle check failed");
// Next-cycle implication, disabled while in reset
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 next-cycle check failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/sha256_pkg.sv @@
// Types, constants and round functions for the SHA-256 digest unit.
// Depends on nothing.
`timescale 1ns / 1ps

package sha256_pkg;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  typedef logic [31:0] word_t;

  localparam logic [5:0]  BLOCK_LAST_POS = 6'd63;
  localparam logic [5:0]  LENGTH_POS     = 6'd56;
  localparam logic [5:0]  ROUND_LAST     = 6'd63;
  localparam logic [1:0]  WORD_LAST_BYTE = 2'd3;
  localparam logic [7:0]  PAD_BYTE       = 8'h80;
  localparam logic [63:0] LEN_STEP       = 64'd8;

  localparam word_t INITIAL_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Sigma0 of the round: rotr 2, 13, 22
  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Sigma1 of the round: rotr 6, 11, 25
  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // sigma0 of the schedule: rotr 7, rotr 18, shr 3
  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // sigma1 of the schedule: rotr 17, rotr 19, shr 10
  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ rtl/sha256_in_if.sv @@
// Input channel of the SHA-256 digest unit: one message byte per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

@@ rtl/sha256_out_if.sv @@
// Result channel of the SHA-256 digest unit: one digest word per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

@@ rtl/sha256_message_digest_unit.sv @@
// Channel   | Dir | Handshake   | Payload
// in_stream | in  | valid/ready | data_byte[7:0], has_byte, end_of_message
// out_stream| out | valid/ready | digest_word[31:0], word_index[2:0], last_word
//
// A byte that does not fill the block is packed at once, and the next byte can follow
// straight after it. The 64th byte of a block starts 64 rounds on the single round unit,
// then the hash update; no byte is taken until they are done. At end of message padding
// goes in one byte per cycle while no compression runs (up to 72 bytes, with one or two
// compressions), then the eight digest words. Reset is synchronous; no clear pass.
// in_stream.ready is high only while idle; a stalled digest word holds.
//
// SHA-256 digest unit top level; uses sha256_pkg, sha256_in_if,
// sha256_out_if and sha256_message_digest_unit_defines.svh.
`timescale 1ns / 1ps
`include "sha256_message_digest_unit_defines.svh"

module sha256_message_digest_unit (
  input  logic          clk,
  input  logic          rst_n,
  sha256_in_if.sink     in_stream,
  sha256_out_if.source  out_stream
);

  sha256_pkg::state_t state_r, state_nxt;

  // hash, working variables a..h and the 16-word block/schedule window
  sha256_pkg::word_t hash_r [8];
  sha256_pkg::word_t hash_nxt [8];
  sha256_pkg::word_t var_r [8];
  sha256_pkg::word_t var_nxt [8];
  sha256_pkg::word_t w_r [16];
  sha256_pkg::word_t w_nxt [16];

  logic [23:0] acc_r, acc_nxt;      // bytes of the word being packed
  logic [5:0]  pos_r, pos_nxt;      // bytes held in the block
  logic [63:0] len_r, len_nxt;      // message length in bits
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        pad_active_r, pad_active_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_phase_r, len_phase_nxt;
  logic        final_blk_r, final_blk_nxt;

  logic        ins;
  logic [7:0]  ins_byte;
  logic        is_len;
  logic [63:0] len_shift;
  sha256_pkg::word_t t1, t2, w_new;

  // round and schedule datapath
  always_comb begin
    t1 = var_r[7] + sha256_pkg::big_sigma1(var_r[4])
       + ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]))
       + sha256_pkg::ROUND_K[rnd_r] + w_r[0];
    t2 = sha256_pkg::big_sigma0(var_r[0])
       + ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));
    w_new = sha256_pkg::small_sigma1(w_r[14]) + w_r[9]
          + sha256_pkg::small_sigma0(w_r[1]) + w_r[0];
  end

  // padding byte: 0x80 first, zeros, then the length big-endian from pos 56
  assign is_len    = !pad_first_r && (len_phase_r || (pos_r == sha256_pkg::LENGTH_POS));
  assign len_shift = len_r << {pos_r[2:0], 3'b000};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    var_nxt        = var_r;
    w_nxt          = w_r;
    acc_nxt        = acc_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    rnd_nxt        = rnd_r;
    oidx_nxt       = oidx_r;
    pad_active_nxt = pad_active_r;
    pad_first_nxt  = pad_first_r;
    len_phase_nxt  = len_phase_r;
    final_blk_nxt  = final_blk_r;
    ins            = 1'b0;
    ins_byte       = in_stream.data_byte;

    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_stream.valid) begin
          if (in_stream.has_byte) begin
            ins     = 1'b1;
            len_nxt = len_r + sha256_pkg::LEN_STEP;
          end
          if (in_stream.has_byte && (pos_r == sha256_pkg::BLOCK_LAST_POS)) begin
            state_nxt      = sha256_pkg::ST_ROUND;
            pad_active_nxt = in_stream.end_of_message;
            pad_first_nxt  = in_stream.end_of_message;
          end else if (in_stream.end_of_message) begin
            state_nxt      = sha256_pkg::ST_PAD;
            pad_active_nxt = 1'b1;
            pad_first_nxt  = 1'b1;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        ins           = 1'b1;
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          ins_byte = sha256_pkg::PAD_BYTE;
        end else if (is_len) begin
          ins_byte = len_shift[63:56];
        end else begin
          ins_byte = 8'h00;
        end
        if (is_len) begin
          len_phase_nxt = 1'b1;
        end
        if (pos_r == sha256_pkg::BLOCK_LAST_POS) begin
          state_nxt     = sha256_pkg::ST_ROUND;
          final_blk_nxt = is_len;
        end
      end
      sha256_pkg::ST_ROUND: begin
        // one round per cycle; window slides by one word
        var_nxt[0] = t1 + t2;
        var_nxt[1] = var_r[0];
        var_nxt[2] = var_r[1];
        var_nxt[3] = var_r[2];
        var_nxt[4] = var_r[3] + t1;
        var_nxt[5] = var_r[4];
        var_nxt[6] = var_r[5];
        var_nxt[7] = var_r[6];
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[15] = w_new;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == sha256_pkg::ROUND_LAST) begin
          state_nxt = sha256_pkg::ST_UPDATE;
        end
      end
      sha256_pkg::ST_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + var_r[i];
        end
        if (final_blk_r) begin
          state_nxt = sha256_pkg::ST_OUT;
          oidx_nxt  = 3'd0;
        end else if (pad_active_r) begin
          state_nxt = sha256_pkg::ST_PAD;
        end else begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_stream.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (&oidx_r) begin
            // digest out: back to the initial state for the next message
            state_nxt      = sha256_pkg::ST_IDLE;
            hash_nxt       = sha256_pkg::INITIAL_HASH;
            len_nxt        = '0;
            pad_active_nxt = 1'b0;
            pad_first_nxt  = 1'b0;
            len_phase_nxt  = 1'b0;
            final_blk_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase

    // byte packing, shared by message and padding bytes
    if (ins) begin
      acc_nxt = {acc_r[15:0], ins_byte};
      pos_nxt = pos_r + 6'd1;
      if (pos_r[1:0] == sha256_pkg::WORD_LAST_BYTE) begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[15] = {acc_r, ins_byte};
      end
      if (pos_r == sha256_pkg::BLOCK_LAST_POS) begin
        var_nxt = hash_r;
        rnd_nxt = 6'd0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sha256_pkg::ST_IDLE;
      hash_r       <= sha256_pkg::INITIAL_HASH;
      pos_r        <= '0;
      len_r        <= '0;
      rnd_r        <= '0;
      oidx_r       <= '0;
      pad_active_r <= 1'b0;
      pad_first_r  <= 1'b0;
      len_phase_r  <= 1'b0;
      final_blk_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hash_r       <= hash_nxt;
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      rnd_r        <= rnd_nxt;
      oidx_r       <= oidx_nxt;
      pad_active_r <= pad_active_nxt;
      pad_first_r  <= pad_first_nxt;
      len_phase_r  <= len_phase_nxt;
      final_blk_r  <= final_blk_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    var_r <= var_nxt;
    w_r   <= w_nxt;
    acc_r <= acc_nxt;
  end

  // ports
  assign in_stream.ready        = (state_r == sha256_pkg::ST_IDLE);
  assign out_stream.valid       = (state_r == sha256_pkg::ST_OUT);
  assign out_stream.digest_word = hash_r[oidx_r];
  assign out_stream.word_index  = oidx_r;
  assign out_stream.last_word   = &oidx_r;

  // checks
  `SHA_ASSERT_IMP(a_no_overlap, clk, rst_n, out_stream.valid, !in_stream.ready)
  `SHA_ASSERT_IMP(a_round_aligned, clk, rst_n, (state_r == sha256_pkg::ST_ROUND), (pos_r == 6'd0))
  `SHA_ASSERT_NXT(a_round_end, clk, rst_n, (state_r == sha256_pkg::ST_ROUND) && (rnd_r == sha256_pkg::ROUND_LAST), (state_r == sha256_pkg::ST_UPDATE))
  `SHA_ASSERT_NXT(a_digest_done, clk, rst_n, out_stream.valid && out_stream.ready && out_stream.last_word, (state_r == sha256_pkg::ST_IDLE) && (len_r == 64'd0) && !pad_active_r)
  `SHA_ASSERT_IMP(a_len_in_pad, clk, rst_n, len_phase_r, pad_active_r)

endmodule

@@ tb/sha256_message_digest_checker.sv @@
// Scoreboard for the SHA-256 digest unit: hashes every accepted input word
// on its own and compares each digest word that leaves the block.
// Depends on sha256_pkg, sha256_in_if and sha256_out_if.
`timescale 1ns / 1ps

module sha256_message_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  sha256_in_if        in_ch,
  sha256_out_if       out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    sha256_pkg::word_t value;
    logic [2:0]        index;
    logic              last;
  } digest_entry_t;

  // Running hash state, mirrored from the message seen so far
  sha256_pkg::word_t chain_hash [8];
  sha256_pkg::word_t blk_words [16];
  logic [63:0]       msg_bits;
  logic [5:0]        fill_pos;

  // Digest words still owed by the block, oldest first
  digest_entry_t digest_q [$];

  function automatic sha256_pkg::word_t rotr(input sha256_pkg::word_t x,
                                             input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    chain_hash = sha256_pkg::INITIAL_HASH;
    msg_bits   = '0;
    fill_pos   = '0;
  endfunction

  // 64 rounds over the current block, schedule kept in a 16-word window
  function automatic void compress_block();
    sha256_pkg::word_t w [16];
    sha256_pkg::word_t v [8];
    sha256_pkg::word_t wt, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk_words[i];
    for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s0 = rotr(w[(t - 15) & 15], 7) ^ rotr(w[(t - 15) & 15], 18)
           ^ (w[(t - 15) & 15] >> 3);
        s1 = rotr(w[(t - 2) & 15], 17) ^ rotr(w[(t - 2) & 15], 19)
           ^ (w[(t - 2) & 15] >> 10);
        wt = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
        w[t & 15] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
  endfunction

  // Big-endian byte packing; a full block is compressed at once
  function automatic void place_byte(input logic [7:0] v);
    logic [3:0]  wi;
    int unsigned sh;
    wi = fill_pos[5:2];
    sh = (3 - fill_pos[1:0]) * 8;
    if (fill_pos[1:0] == 2'd0) blk_words[wi] = '0;
    blk_words[wi] = blk_words[wi] | (sha256_pkg::word_t'(v) << sh);
    if (fill_pos == sha256_pkg::BLOCK_LAST_POS) compress_block();
    fill_pos = fill_pos + 6'd1;
  endfunction

  // One input word: byte first, then padding and digest on end of message
  function automatic void hash_item(input logic [7:0] d, input logic h, input logic e);
    logic [63:0]   len;
    digest_entry_t ent;
    if (h) begin
      place_byte(d);
      msg_bits = msg_bits + sha256_pkg::LEN_STEP;
    end
    if (e) begin
      len = msg_bits;
      place_byte(sha256_pkg::PAD_BYTE);
      while (fill_pos != sha256_pkg::LENGTH_POS) place_byte(8'h00);
      for (int i = 0; i < 8; i++) place_byte(len[63 - 8 * i -: 8]);
      for (int i = 0; i < 8; i++) begin
        ent.value = chain_hash[i];
        ent.index = 3'(i);
        ent.last  = (i == 7);
        digest_q.push_back(ent);
      end
      restart_message();
    end
  endfunction

  always @(posedge clk) begin : score
    digest_entry_t want;
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
      fail_count = 0;
    end else begin
      // Result side first: compare against the oldest owed digest word
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                   out_ch.digest_word, out_ch.word_index, out_ch.last_word);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          if (out_ch.digest_word !== want.value || out_ch.word_index !== want.index ||
              out_ch.last_word !== want.last) begin
            $display("%0t: digest mismatch: expected %h idx %0d last %0b, %s",
                     $time, want.value, want.index, want.last,
                     $sformatf("got %h idx %0d last %0b", out_ch.digest_word,
                               out_ch.word_index, out_ch.last_word));
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        hash_item(in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message);
    end
    pending <= digest_q.size();
  end

endmodule

@@ tb/sha256_message_digest_unit_tb.sv @@
// Top of the SHA-256 digest unit bench: clock, reset, byte stimulus,
// result back-pressure, watchdog and verdict.
// Depends on sha256_pkg, both channel interfaces and the digest checker.
`timescale 1ns / 1ps

module sha256_message_digest_unit_tb;

  typedef enum logic [1:0] {
    RX_FULL,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  localparam int unsigned ITEM_TARGET = 420;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned HOLD_AFTER  = 6;
  localparam int unsigned DRAIN_WAIT  = 200;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned burst_left  = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_message_digest_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  sha256_message_digest_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one word; bursts of random length separated by random gaps
  task automatic send_word(input logic [7:0] d, input logic h, input logic e);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= d;
    in_ch.has_byte       <= h;
    in_ch.end_of_message <= e;
    do @(posedge clk); while (!in_ch.ready);
    if (h || e) items_sent++;
  endtask

  // Random bytes with stray empty words; closed on the last byte or by an end-only word
  task automatic send_message(input int unsigned len, input bit close_on_byte);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stimulus
  initial begin : stim
    int unsigned len;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= '0;
    in_ch.has_byte       <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty word, empty message, "abc", byte extremes, byte with end
    send_word(8'h5a, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h80, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);

    // Random messages, lengths weighted toward the padding boundaries
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: len = $urandom_range(0, 16);
        5, 6, 7:       len = $urandom_range(50, 70);
        8:             len = $urandom_range(110, 135);
        default: begin
          case ($urandom_range(0, 3))
            0:       len = 55;
            1:       len = 56;
            2:       len = 63;
            default: len = 64;
          endcase
        end
      endcase
      if ($urandom_range(0, 7) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_message(len, $urandom_range(0, 1));
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("sha256_message_digest_unit_tb OK");
    else
      $display("sha256_message_digest_unit_tb NOT OK");
    $finish;
  end

  // Result side: changing ready patterns, plus one long hold-off so the input backs up
  initial begin : rx_side
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned digests_seen;
    bit          hold_done;
    mode         = RX_FULL;
    mode_left    = 0;
    hold_left    = 0;
    digests_seen = 0;
    hold_done    = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready && out_ch.last_word) digests_seen++;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && digests_seen == HOLD_AFTER && out_ch.valid === 1'b1) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          RX_FULL:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sha256_message_digest_unit_tb NOT OK");
      $finish;
    end
  end

endmodule

@@ sha256_message_digest_unit.f @@
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_in_if.sv
rtl/sha256_out_if.sv
rtl/sha256_message_digest_unit.sv
tb/sha256_message_digest_checker.sv
tb/sha256_message_digest_unit_tb.sv
